[hdl/scfd_pkg.sv]
package scfd_pkg;

  localparam int WIN_DEPTH   = 32;
  localparam int FILL_W      = $clog2(WIN_DEPTH + 1);
  localparam int FRAME_MAX   = 23;
  localparam int FLEN_W      = $clog2(FRAME_MAX + 1);
  localparam int MIN_HELD    = 6;
  localparam int MAX_RESULTS = 5;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int DATA_BYTES  = 15;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 160;

  localparam logic [7:0] HEAD_BYTE = 8'hA5;
  localparam logic [7:0] TAIL_BYTE = 8'h5A;
  localparam logic [3:0] CMD_CH1   = 4'h1;
  localparam logic [FLEN_W-1:0] FLEN_STD = FLEN_W'(5);
  localparam logic [FLEN_W-1:0] FLEN_EXT = FLEN_W'(8);

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [55:0] data_high;
    logic [63:0] data_low;
    logic [31:0] frame_id;
    logic [3:0]  data_length;
    logic        extended_id;
    logic        second_channel;
  } result_t;

  typedef struct packed {
    logic              is_head;
    logic              complete;
    logic              tail_ok;
    logic [FLEN_W-1:0] flen;
  } scan_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SKIP,
    ST_FLUSH
  } state_t;

endpackage

[hdl/scfd_cell.sv]
module scfd_cell (
  input  logic          clk,
  input  logic          shift,
  input  logic          load,
  input  scfd_pkg::byte_t din_load,
  input  scfd_pkg::byte_t din_next,
  output scfd_pkg::byte_t q
);
  import scfd_pkg::*;

  byte_t byte_r;
  byte_t byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (load) begin
      byte_nxt = din_load;
    end else if (shift) begin
      byte_nxt = din_next;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign q = byte_r;

endmodule

[hdl/scfd_parse.sv]
module scfd_parse (
  input  scfd_pkg::byte_t               taps [scfd_pkg::FRAME_MAX],
  input  logic [scfd_pkg::FILL_W-1:0]   fill,
  output scfd_pkg::scan_t               scan,
  output scfd_pkg::result_t             res
);
  import scfd_pkg::*;

  logic [3:0]        dlc;
  logic              ext;
  logic [FLEN_W-1:0] flen;
  logic [FLEN_W-1:0] tail_idx;
  byte_t             db [DATA_BYTES];

  assign dlc      = taps[2][7:4];
  assign ext      = taps[2][0];
  assign flen     = (ext ? FLEN_EXT : FLEN_STD) + FLEN_W'(dlc);
  assign tail_idx = flen - FLEN_W'(1);

  assign scan.is_head  = (taps[0] == HEAD_BYTE);
  assign scan.complete = (fill >= FILL_W'(flen));
  assign scan.tail_ok  = (taps[tail_idx] == TAIL_BYTE);
  assign scan.flen     = flen;

  for (genvar k = 0; k < DATA_BYTES; k++) begin : g_data
    assign db[k] = (4'(k) < dlc) ? (ext ? taps[7 + k] : taps[4 + k]) : 8'h00;
  end

  always_comb begin
    res.second_channel = (taps[1][3:0] != CMD_CH1);
    res.extended_id    = ext;
    res.data_length    = dlc;
    res.frame_id       = ext ? {taps[3], taps[4], taps[5], taps[6]} : {24'h0, taps[3]};
    res.data_low       = '0;
    res.data_high      = '0;
    for (int k = 0; k < 8; k++) begin
      res.data_low[8*k +: 8] = db[k];
    end
    for (int k = 8; k < DATA_BYTES; k++) begin
      res.data_high[8*(k-8) +: 8] = db[k];
    end
  end

endmodule

[hdl/serial_can_frame_deframer_unit.sv]
// Serial CAN frame deframer.
// in_*  : one received serial byte per beat (in_tdata[7:0] = rx_byte).
// out_* : one decoded frame per beat; out_tlast marks the last frame found
//         after one input byte.
// Bytes sit in a row of byte cells that shifts toward the front one cell per
// cycle while a scan drops or consumes bytes. The front cells are decoded
// each cycle: a non-head byte or a frame with a bad tail drops one byte, a
// good frame is captured and its bytes are shifted out one per cycle.
// An input byte enters the row first, then the scan drops or consumes bytes,
// then ST_FLUSH ends the scan. in_tready is high only between scans, so a
// new byte is taken only after the scan for the last one has ended.
// A found frame is held in a pending register until the next frame or the
// end of the scan decides its tlast, then moves to the output register.
// When the receiver stalls, the output register holds; the scan and its end
// wait while the pending frame must move on and the output register is full.
// Reset empties the window and clears all valid flags; no clearing pass.
module serial_can_frame_deframer_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [scfd_pkg::IN_TDATA_W-1:0]     in_tdata,   // [7:0] rx_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] second_channel, [1] extended_id, [5:2] data_length, [37:6] frame_id,
  // [101:38] data_low, [157:102] data_high, [159:158] zero
  output logic [scfd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tlast   // last_in_run
);
  import scfd_pkg::*;

  state_t            state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [FLEN_W-1:0] skip_r, skip_nxt;
  logic              pend_v_r, pend_v_nxt;
  result_t           pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;

  logic              accept;
  logic              append;
  logic              shift;
  logic              out_free;
  byte_t             win_q [WIN_DEPTH];
  byte_t             taps [FRAME_MAX];
  scan_t             scan;
  result_t           res;

  assign accept   = in_tvalid && in_tready;
  assign append   = accept && (fill_r < FILL_W'(WIN_DEPTH));
  assign out_free = !out_valid_r || out_tready;

  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
    byte_t nxt_byte;
    if (i == WIN_DEPTH - 1) begin : g_end
      assign nxt_byte = 8'h00;
    end else begin : g_mid
      assign nxt_byte = win_q[i + 1];
    end
    scfd_cell u_cell (
      .clk      (clk),
      .shift    (shift),
      .load     (append && (fill_r == FILL_W'(i))),
      .din_load (in_tdata),
      .din_next (nxt_byte),
      .q        (win_q[i])
    );
  end

  for (genvar i = 0; i < FRAME_MAX; i++) begin : g_tap
    assign taps[i] = win_q[i];
  end

  scfd_parse u_parse (
    .taps (taps),
    .fill (fill_r),
    .scan (scan),
    .res  (res)
  );

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    count_nxt     = count_r;
    skip_nxt      = skip_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    shift         = 1'b0;
    in_tready     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (accept) begin
          if (append) begin
            fill_nxt = fill_r + FILL_W'(1);
          end
          count_nxt = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (fill_r < FILL_W'(MIN_HELD) || count_r == CNT_W'(MAX_RESULTS)) begin
          state_nxt = ST_FLUSH;
        end else if (!scan.is_head) begin
          shift    = 1'b1;
          fill_nxt = fill_r - FILL_W'(1);
        end else if (!scan.complete) begin
          state_nxt = ST_FLUSH;
        end else if (!scan.tail_ok) begin
          shift    = 1'b1;
          fill_nxt = fill_r - FILL_W'(1);
        end else if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = pend_r;
            out_last_nxt  = 1'b0;
          end
          pend_v_nxt = 1'b1;
          pend_nxt   = res;
          count_nxt  = count_r + CNT_W'(1);
          shift      = 1'b1;
          fill_nxt   = fill_r - FILL_W'(1);
          skip_nxt   = scan.flen - FLEN_W'(1);
          state_nxt  = ST_SKIP;
        end
      end
      ST_SKIP: begin
        shift    = 1'b1;
        fill_nxt = fill_r - FILL_W'(1);
        skip_nxt = skip_r - FLEN_W'(1);
        if (skip_r == FLEN_W'(1)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = pend_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      count_r     <= '0;
      skip_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      count_r     <= count_nxt;
      skip_r      <= skip_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - $bits(result_t))'(0), out_data_r};
  assign out_tlast  = out_last_r;

endmodule

[tb/scfd_checker.sv]
module scfd_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [scfd_pkg::IN_TDATA_W-1:0]  in_tdata,    // [7:0] rx_byte
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] second_channel, [1] extended_id, [5:2] data_length, [37:6] frame_id,
  // [101:38] data_low, [157:102] data_high, [159:158] zero
  input  logic [scfd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             out_tlast,
  output int                               frames_pending,
  output int                               fail_count
);
  import scfd_pkg::*;

  typedef struct packed {
    result_t fields;
    logic    last;
  } frame_exp_t;

  frame_exp_t expected_frames[$];
  byte_t      held_bytes[WIN_DEPTH];
  int         held_count;
  int         frames_seen;
  result_t    got;
  frame_exp_t want;

  initial begin
    fail_count  = 0;
    held_count  = 0;
    frames_seen = 0;
  end

  task automatic report_error(input string msg);
    $display("%0t: frame %0d: %s", $time, frames_seen, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] seen_val,
                             input logic [63:0] want_val);
    if (seen_val !== want_val)
      report_error($sformatf("%s is %0h, expected %0h", name, seen_val, want_val));
  endtask

  // Append one byte, then scan the held bytes for complete frames.
  task automatic deframe_byte(input byte_t rx);
    result_t    found[MAX_RESULTS];
    result_t    r;
    frame_exp_t item;
    int         pos;
    int         nfound;
    int         dlc;
    int         idlen;
    int         flen;
    int         base;
    logic       ext;

    pos    = 0;
    nfound = 0;
    if (held_count < WIN_DEPTH) begin
      held_bytes[held_count] = rx;
      held_count++;
    end
    while (held_count - pos >= MIN_HELD && nfound < MAX_RESULTS) begin
      if (held_bytes[pos] != HEAD_BYTE) begin
        pos++;
        continue;
      end
      ext   = held_bytes[pos+2][0];
      dlc   = held_bytes[pos+2][7:4];
      idlen = ext ? 4 : 1;
      flen  = 4 + idlen + dlc;
      if (held_count - pos < flen)
        break;
      if (held_bytes[pos+flen-1] != TAIL_BYTE) begin
        pos++;
        continue;
      end
      r = '0;
      r.second_channel = (held_bytes[pos+1][3:0] != CMD_CH1);
      r.extended_id    = ext;
      r.data_length    = 4'(dlc);
      if (ext)
        r.frame_id = {held_bytes[pos+3], held_bytes[pos+4],
                      held_bytes[pos+5], held_bytes[pos+6]};
      else
        r.frame_id = {24'h0, held_bytes[pos+3]};
      base = pos + 3 + idlen;
      for (int k = 0; k < dlc; k++) begin
        if (k < 8)
          r.data_low[8*k +: 8] = held_bytes[base+k];
        else
          r.data_high[8*(k-8) +: 8] = held_bytes[base+k];
      end
      found[nfound] = r;
      nfound++;
      pos += flen;
    end
    if (pos > 0) begin
      for (int i = 0; i < held_count - pos; i++)
        held_bytes[i] = held_bytes[i+pos];
      held_count -= pos;
    end
    for (int i = 0; i < nfound; i++) begin
      item.fields = found[i];
      item.last   = (i == nfound - 1);
      expected_frames.insert(expected_frames.size(), item);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_count = 0;
      expected_frames.delete();
    end else begin
      if (in_tvalid && in_tready)
        deframe_byte(in_tdata[7:0]);
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[$bits(result_t)-1:0]);
        if (expected_frames.size() == 0) begin
          report_error("frame beat with no frame expected");
        end else begin
          want = expected_frames.pop_front();
          check_field("second_channel", got.second_channel, want.fields.second_channel);
          check_field("extended_id", got.extended_id, want.fields.extended_id);
          check_field("data_length", got.data_length, want.fields.data_length);
          check_field("frame_id", got.frame_id, want.fields.frame_id);
          check_field("data_low", got.data_low, want.fields.data_low);
          check_field("data_high", got.data_high, want.fields.data_high);
          check_field("tlast", out_tlast, want.last);
          check_field("pad bits", out_tdata[OUT_TDATA_W-1:$bits(result_t)], '0);
        end
        frames_seen++;
      end
    end
    frames_pending <= expected_frames.size();
  end

endmodule

[tb/tb.sv]
module tb;
  import scfd_pkg::*;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;    // [7:0] rx_byte
  logic                   out_tvalid;
  logic                   out_tready;
  // [0] second_channel, [1] extended_id, [5:2] data_length, [37:6] frame_id,
  // [101:38] data_low, [157:102] data_high, [159:158] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  int   frames_pending;
  int   fail_count;
  int   bytes_sent;
  int   frames_taken;
  logic send_burst;
  logic recv_burst;
  logic held_off;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  serial_can_frame_deframer_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  scfd_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .frames_pending (frames_pending),
    .fail_count     (fail_count)
  );

  task automatic send_byte(input byte_t b);
    int gap;

    if ($urandom_range(0, 39) == 0)
      send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (in_tready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic send_frame(input byte_t cmd, input logic ext, input int dlc,
                            input logic [31:0] id, input logic rand_data,
                            input byte_t fill, input logic bad_tail);
    byte_t tail;

    send_byte(HEAD_BYTE);
    send_byte(cmd);
    send_byte({4'(dlc), 3'($urandom), ext});
    if (ext) begin
      send_byte(id[31:24]);
      send_byte(id[23:16]);
      send_byte(id[15:8]);
    end
    send_byte(id[7:0]);
    for (int k = 0; k < dlc; k++)
      send_byte(rand_data ? byte_t'($urandom) : fill);
    tail = TAIL_BYTE;
    if (bad_tail)
      do tail = byte_t'($urandom); while (tail == TAIL_BYTE);
    send_byte(tail);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (frames_pending != 0);
  endtask

  initial begin
    byte_t cmd;
    logic  drained_once;

    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    send_burst   = 1'b0;
    bytes_sent   = 0;
    drained_once = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // short lone frame, held until a sixth byte arrives
    send_frame(8'h01, 1'b0, 0, 32'h0, 1'b0, 8'h00, 1'b0);
    send_byte(8'h00);
    // longest frame, all ones
    send_frame(8'hFF, 1'b1, 15, 32'hFFFF_FFFF, 1'b0, 8'hFF, 1'b0);

    while (bytes_sent < 420) begin
      if (!drained_once && bytes_sent >= 200) begin
        wait_drain();
        drained_once = 1'b1;
      end
      cmd = {4'($urandom), $urandom_range(0, 1) ? CMD_CH1 : 4'($urandom)};
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          send_frame(cmd, 1'($urandom_range(0, 1)), $urandom_range(0, 15), $urandom,
                     1'b1, 8'h00, 1'b0);
        end
        6: begin
          send_frame(cmd, 1'($urandom_range(0, 1)), $urandom_range(0, 15), $urandom,
                     1'b1, 8'h00, 1'b1);
        end
        7: begin
          repeat ($urandom_range(1, 3)) send_byte(byte_t'($urandom));
        end
        8: begin
          // long frame with a bad tail that hides three short frames
          send_byte(HEAD_BYTE);
          send_byte(8'h21);
          send_byte(8'hF1);
          repeat (3) send_frame(cmd, 1'b0, 0, $urandom, 1'b1, 8'h00, 1'b0);
          repeat (5) send_byte(8'h00);
        end
        default: begin
          send_byte(HEAD_BYTE);
          send_byte(cmd);
          send_byte(byte_t'($urandom));
        end
      endcase
    end

    wait_drain();
    repeat (60) @(posedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int gap;

    out_tready   <= 1'b0;
    recv_burst   = 1'b0;
    held_off     = 1'b0;
    frames_taken = 0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (!held_off && frames_taken == 12) begin
        // hold off long enough for the block to stall its input
        gap      = 400;
        held_off = 1'b1;
      end else begin
        if ($urandom_range(0, 29) == 0)
          recv_burst = !recv_burst;
        gap = recv_burst ? 0 : $urandom_range(0, 4);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      frames_taken++;
    end
  end

  initial begin
    #6_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
hdl/scfd_pkg.sv
hdl/scfd_cell.sv
hdl/scfd_parse.sv
hdl/serial_can_frame_deframer_unit.sv
tb/scfd_checker.sv
tb/tb.sv
